FILE: design/hpa_pkg.sv
// ---------------------------------------------------------------------------
// hpa_pkg: shared definitions for the hsi pixel adjust pipeline
// fixed point widths, cordic arctangent table, register codes, stage types
// ---------------------------------------------------------------------------
package hpa_pkg;

  // hue fraction bits (valid range 4..12)
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int INT_FRAC        = 6;
  localparam int SAT_FRAC        = 8;
  localparam int CORDIC_STEPS    = 16;
  localparam int DEG             = 65536;
  localparam int SAT_FULL        = 25600;

  // widths
  localparam int IVAL_W   = 14;
  localparam int SVAL_W   = 15;
  localparam int HVAL_W   = $clog2((360 << ANGLE_FRAC_BITS) + 1);
  localparam int ADJ_W    = ((HVAL_W > 18) ? HVAL_W : 18) + 2;
  localparam int ANG_W    = 26;
  localparam int VEC_W    = 27;
  localparam int A_W      = 24;
  localparam int RZ_W     = A_W + 1;
  localparam int ROT_W    = 19;
  localparam int SNUM_W   = 25;
  localparam int SAT_Q_W  = 15;
  localparam int RREM_W   = 35;
  localparam int DEN_W    = 17;
  localparam int RQ_W     = 18;
  localparam int PROD_W   = 29;
  localparam int LM_W     = PROD_W + 1 - 10;
  localparam int P2_W     = 48;
  localparam int MB_W     = P2_W - 26;
  localparam int V_W      = 21;

  // stage count from start transfer to done strobe
  localparam int PIPE_DEPTH = 62;

  // reciprocal constants for division by 3 and by 25
  localparam logic [15:0] RECIP3     = 16'd43691;
  localparam logic [19:0] RECIP25_L  = 20'd671089;
  localparam logic [21:0] RECIP25_B  = 22'd2684355;
  localparam int          HALF_BIG   = 838860800;

  // register indexes
  localparam logic REG_ADJUST_MODE = 1'b0;
  localparam logic REG_OFFSET      = 1'b1;

  // adjust modes
  localparam logic [1:0] MODE_INTENSITY  = 2'd0;
  localparam logic [1:0] MODE_SATURATION = 2'd1;
  localparam logic [1:0] MODE_HUE        = 2'd2;

  // back conversion sectors
  localparam logic [1:0] SEC_RG = 2'd0;
  localparam logic [1:0] SEC_GB = 2'd1;
  localparam logic [1:0] SEC_BR = 2'd2;

  // arctangent of 2^-k in q16 degrees
  localparam logic signed [ANG_W-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  typedef struct packed {
    logic [IVAL_W-1:0]       ival;
    logic [9:0]              sum;
    logic                    gray;
    logic                    bgtg;
    logic                    dzero;
    logic                    xpos;
    logic signed [VEC_W-1:0] cx;
    logic signed [VEC_W-1:0] cy;
    logic signed [ANG_W-1:0] cz;
    logic [SNUM_W-1:0]       srem;
    logic [SAT_Q_W-1:0]      squo;
  } front_t;

  typedef struct packed {
    logic [1:0]              sector;
    logic [IVAL_W-1:0]       ival;
    logic [PROD_W-1:0]       p_low;
    logic [PROD_W-1:0]       p_is;
    logic                    neg;
    logic signed [ROT_W-1:0] x1;
    logic signed [ROT_W-1:0] y1;
    logic signed [RZ_W-1:0]  z1;
    logic signed [ROT_W-1:0] x2;
    logic signed [ROT_W-1:0] y2;
    logic signed [RZ_W-1:0]  z2;
  } rot_t;

  typedef struct packed {
    logic [1:0]        sector;
    logic [IVAL_W-1:0] ival;
    logic [PROD_W-1:0] p_low;
    logic [PROD_W-1:0] p_is;
    logic              neg;
    logic [RREM_W-1:0] rem;
    logic [DEN_W-1:0]  den;
    logic [RQ_W-1:0]   quo;
  } div_t;

  function automatic logic signed [ADJ_W-1:0] clamp_adj(
    input logic signed [ADJ_W-1:0] v,
    input logic signed [ADJ_W-1:0] hi
  );
    logic signed [ADJ_W-1:0] res;
    res = v;
    if (v < 0) begin
      res = '0;
    end else if (v > hi) begin
      res = hi;
    end
    return res;
  endfunction

  // q.6 channel to 8 bits, negative to 0, saturate at 255
  function automatic logic [7:0] chan_out(input logic signed [V_W-1:0] v);
    logic signed [V_W:0] t;
    logic [7:0]          res;
    t = V_W'(v) + (V_W+1)'(32);
    if (v < 0) begin
      res = 8'd0;
    end else if (t[V_W:INT_FRAC] > (V_W+1-INT_FRAC)'(255)) begin
      res = 8'd255;
    end else begin
      res = t[INT_FRAC +: 8];
    end
    return res;
  endfunction

endpackage

FILE: design/hsi_pixel_adjust.sv
// ---------------------------------------------------------------------------
// hsi_pixel_adjust: per-pixel hsi adjustment of a bgr pixel
// rgb to hsi, offset on one component, hsi back to rgb, fully pipelined
// ---------------------------------------------------------------------------
// One pixel enters on every clock at which start is high (busy is never
// raised) and its adjusted pixel leaves on the single-cycle done strobe;
// the receiver cannot stall, so no transfer is ever held back.
// The pipeline depth comes from the 16-step cordic vectoring chain for hue
// (with the 15-bit saturation divider beside it), the two 16-step cordic
// cosine rotators and the 18-step ratio divider, each one stage per step.
// adjust_mode and offset are written through cfg_valid/cfg_ready and must
// only change while no pixel is in flight.
module hsi_pixel_adjust
  import hpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] blue_in,
  input  logic [7:0] green_in,
  input  logic [7:0] red_in,
  output logic       done,
  output logic [7:0] blue_out,
  output logic [7:0] green_out,
  output logic [7:0] red_out,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [9:0] cfg_data
);

  localparam logic signed [ANG_W-1:0] ANG_90  = ANG_W'(90 * DEG);
  localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(180 * DEG);
  localparam logic signed [ANG_W-1:0] ANG_360 = ANG_W'(360 * DEG);
  localparam logic signed [RZ_W-1:0]  RZ_60   = RZ_W'(60 * DEG);
  localparam logic signed [RZ_W-1:0]  RZ_90   = RZ_W'(90 * DEG);
  localparam logic signed [RZ_W-1:0]  RZ_180  = RZ_W'(180 * DEG);
  localparam logic signed [ROT_W-1:0] ROT_X0  = ROT_W'(39797);
  localparam logic [HVAL_W-1:0] HUE_120 = HVAL_W'(120 << ANGLE_FRAC_BITS);
  localparam logic [HVAL_W-1:0] HUE_240 = HVAL_W'(240 << ANGLE_FRAC_BITS);
  localparam logic signed [ADJ_W-1:0] IVAL_MAX = ADJ_W'(255 << INT_FRAC);
  localparam logic signed [ADJ_W-1:0] SVAL_MAX = ADJ_W'(SAT_FULL);
  localparam logic signed [ADJ_W-1:0] HVAL_MAX = ADJ_W'(360 << ANGLE_FRAC_BITS);

  // -------------------------------------------------------------------------
  // configuration registers, writes always taken
  // -------------------------------------------------------------------------
  logic [1:0]        adjust_mode;
  logic signed [9:0] offset;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      adjust_mode <= MODE_INTENSITY;
      offset      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ADJUST_MODE: adjust_mode <= cfg_data[1:0];
        REG_OFFSET:      offset      <= $signed(cfg_data);
        default:         ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // valid bits travel alongside the stage registers
  // -------------------------------------------------------------------------
  logic [PIPE_DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_DEPTH-2:0], start & ~busy};
    end
  end

  assign done = vld[PIPE_DEPTH-1];

  // -------------------------------------------------------------------------
  // input register
  // -------------------------------------------------------------------------
  logic [7:0] b0, g0, r0;

  always_ff @(posedge clk) begin
    b0 <= blue_in;
    g0 <= green_in;
    r0 <= red_in;
  end

  // -------------------------------------------------------------------------
  // sum, minimum, hue differences
  // -------------------------------------------------------------------------
  logic [9:0]         sum_c;
  logic [7:0]         mn_c, d_c;
  logic signed [10:0] sdiff_c;
  logic [9:0]         sum1;
  logic [7:0]         mn1, d1;
  logic signed [10:0] sdiff1;
  logic               gray1, bgtg1;

  always_comb begin
    sum_c   = {2'b0, b0} + {2'b0, g0} + {2'b0, r0};
    mn_c    = (b0 < g0) ? b0 : g0;
    if (r0 < mn_c) begin
      mn_c = r0;
    end
    sdiff_c = $signed({2'b0, r0, 1'b0}) - $signed({3'b0, g0}) - $signed({3'b0, b0});
    d_c     = (g0 > b0) ? (g0 - b0) : (b0 - g0);
  end

  always_ff @(posedge clk) begin
    sum1   <= sum_c;
    mn1    <= mn_c;
    d1     <= d_c;
    sdiff1 <= sdiff_c;
    gray1  <= (r0 == g0) && (g0 == b0);
    bgtg1  <= b0 > g0;
  end

  // -------------------------------------------------------------------------
  // intensity by reciprocal of 3, saturation numerator, cordic start vector
  // -------------------------------------------------------------------------
  front_t front [CORDIC_STEPS+1];

  logic [15:0]             inum_c;
  logic [31:0]             iprod_c;
  logic [9:0]              spread_c;
  logic [22:0]             ymag_c;
  logic signed [VEC_W-1:0] xv_c, yv_c;
  front_t                  f0_c;

  always_comb begin
    inum_c   = {sum1, 6'b0} + 16'd1;
    iprod_c  = {16'b0, inum_c} * {16'b0, RECIP3};
    spread_c = sum1 - ({2'b0, mn1} + {1'b0, mn1, 1'b0});
    ymag_c   = {15'b0, d1} * 23'd28378;
    xv_c     = {{(VEC_W-25){sdiff1[10]}}, sdiff1, 14'b0};
    yv_c     = $signed({{(VEC_W-23){1'b0}}, ymag_c});

    f0_c       = '0;
    f0_c.ival  = iprod_c[17 +: IVAL_W];
    f0_c.sum   = sum1;
    f0_c.gray  = gray1;
    f0_c.bgtg  = bgtg1;
    f0_c.dzero = (d1 == 8'd0);
    f0_c.xpos  = sdiff1 > 0;
    f0_c.srem  = SNUM_W'(spread_c) * SNUM_W'(SAT_FULL) + SNUM_W'(sum1 >> 1);
    f0_c.squo  = '0;
    // left half plane: pre-rotate by 90 degrees
    if (xv_c < 0) begin
      f0_c.cx = yv_c;
      f0_c.cy = -xv_c;
      f0_c.cz = ANG_90;
    end else begin
      f0_c.cx = xv_c;
      f0_c.cy = yv_c;
      f0_c.cz = '0;
    end
  end

  always_ff @(posedge clk) begin
    front[0] <= f0_c;
  end

  // cordic vectoring for theta, saturation divider one quotient bit a stage
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
    localparam int SB = (k < SAT_Q_W) ? (SAT_Q_W - 1 - k) : 0;
    front_t front_next;

    always_comb begin
      front_next = front[k];
      if (front[k].cy > 0) begin
        front_next.cx = front[k].cx + (front[k].cy >>> k);
        front_next.cy = front[k].cy - (front[k].cx >>> k);
        front_next.cz = front[k].cz + ATAN_Q16[k];
      end else begin
        front_next.cx = front[k].cx - (front[k].cy >>> k);
        front_next.cy = front[k].cy + (front[k].cx >>> k);
        front_next.cz = front[k].cz - ATAN_Q16[k];
      end
      if (k < SAT_Q_W) begin
        if (front[k].srem >= (SNUM_W'(front[k].sum) << SB)) begin
          front_next.srem     = front[k].srem - (SNUM_W'(front[k].sum) << SB);
          front_next.squo[SB] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      front[k+1] <= front_next;
    end
  end

  // -------------------------------------------------------------------------
  // hue from theta, gray pixels get hue and saturation 0
  // -------------------------------------------------------------------------
  logic signed [ANG_W-1:0] th_c;
  logic [ANG_W-1:0]        th_rnd_c;
  logic [IVAL_W-1:0]       ival_h;
  logic [SVAL_W-1:0]       sval_h;
  logic [HVAL_W-1:0]       hval_h;

  always_comb begin
    if (front[CORDIC_STEPS].dzero) begin
      th_c = front[CORDIC_STEPS].xpos ? '0 : ANG_180;
    end else if (front[CORDIC_STEPS].cz < 0) begin
      th_c = '0;
    end else if (front[CORDIC_STEPS].cz > ANG_180) begin
      th_c = ANG_180;
    end else begin
      th_c = front[CORDIC_STEPS].cz;
    end
    // blue above green: lower half of the hue circle
    if (front[CORDIC_STEPS].bgtg) begin
      th_c = ANG_360 - th_c;
    end
    th_rnd_c = th_c + ANG_W'(1 << (15 - ANGLE_FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    ival_h <= front[CORDIC_STEPS].ival;
    sval_h <= front[CORDIC_STEPS].gray ? '0 : front[CORDIC_STEPS].squo;
    hval_h <= front[CORDIC_STEPS].gray ? '0 : th_rnd_c[(16 - ANGLE_FRAC_BITS) +: HVAL_W];
  end

  // -------------------------------------------------------------------------
  // offset on the selected component, clamped to its range
  // -------------------------------------------------------------------------
  logic signed [ADJ_W-1:0] off_c, iv_c, sv_c, hv_c;
  logic [IVAL_W-1:0]       ival_a;
  logic [SVAL_W-1:0]       sval_a;
  logic [HVAL_W-1:0]       hval_a;

  always_comb begin
    off_c = ADJ_W'(offset);
    iv_c  = ADJ_W'(ival_h);
    sv_c  = ADJ_W'(sval_h);
    hv_c  = ADJ_W'(hval_h);
    unique case (adjust_mode)
      MODE_INTENSITY:  iv_c = clamp_adj(iv_c + (off_c <<< INT_FRAC), IVAL_MAX);
      MODE_SATURATION: sv_c = clamp_adj(sv_c + (off_c <<< SAT_FRAC), SVAL_MAX);
      MODE_HUE:        hv_c = clamp_adj(hv_c + (off_c <<< ANGLE_FRAC_BITS), HVAL_MAX);
      default:         ; // unused mode: plain round trip
    endcase
  end

  always_ff @(posedge clk) begin
    ival_a <= iv_c[IVAL_W-1:0];
    sval_a <= sv_c[SVAL_W-1:0];
    hval_a <= hv_c[HVAL_W-1:0];
  end

  // -------------------------------------------------------------------------
  // sector select and angle inside the sector
  // -------------------------------------------------------------------------
  logic [1:0]        sector_c;
  logic [HVAL_W-1:0] hdiff_c;
  logic [1:0]        sector_s;
  logic [IVAL_W-1:0] ival_s;
  logic [SVAL_W-1:0] sval_s;
  logic [A_W-1:0]    a_s;

  always_comb begin
    if (hval_a <= HUE_120) begin
      sector_c = SEC_RG;
      hdiff_c  = hval_a;
    end else if (hval_a <= HUE_240) begin
      sector_c = SEC_GB;
      hdiff_c  = hval_a - HUE_120;
    end else begin
      sector_c = SEC_BR;
      hdiff_c  = hval_a - HUE_240;
    end
  end

  always_ff @(posedge clk) begin
    sector_s <= sector_c;
    ival_s   <= ival_a;
    sval_s   <= sval_a;
    a_s      <= A_W'(hdiff_c) << (16 - ANGLE_FRAC_BITS);
  end

  // -------------------------------------------------------------------------
  // cosine rotators: cos(a) and cos(60 - a), plus the two products
  // -------------------------------------------------------------------------
  rot_t                   rot [CORDIC_STEPS+1];
  rot_t                   r0_c;
  logic signed [RZ_W-1:0] a_sg_c;

  always_comb begin
    a_sg_c       = $signed({1'b0, a_s});
    r0_c         = '0;
    r0_c.sector  = sector_s;
    r0_c.ival    = ival_s;
    r0_c.p_low   = PROD_W'(ival_s) * PROD_W'(SVAL_W'(SAT_FULL) - sval_s);
    r0_c.p_is    = PROD_W'(ival_s) * PROD_W'(sval_s);
    r0_c.x1      = ROT_X0;
    r0_c.y1      = '0;
    r0_c.x2      = ROT_X0;
    r0_c.y2      = '0;
    // beyond 90 degrees fold to 180 - a with a sign flip
    if (a_sg_c > RZ_90) begin
      r0_c.z1  = RZ_180 - a_sg_c;
      r0_c.neg = 1'b1;
    end else begin
      r0_c.z1  = a_sg_c;
      r0_c.neg = 1'b0;
    end
    r0_c.z2 = RZ_60 - a_sg_c;
    if (r0_c.z2 < 0) begin
      r0_c.z2 = -r0_c.z2;
    end
  end

  always_ff @(posedge clk) begin
    rot[0] <= r0_c;
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
    rot_t rot_next;

    always_comb begin
      rot_next = rot[k];
      if (rot[k].z1 >= 0) begin
        rot_next.x1 = rot[k].x1 - (rot[k].y1 >>> k);
        rot_next.y1 = rot[k].y1 + (rot[k].x1 >>> k);
        rot_next.z1 = rot[k].z1 - RZ_W'(ATAN_Q16[k]);
      end else begin
        rot_next.x1 = rot[k].x1 + (rot[k].y1 >>> k);
        rot_next.y1 = rot[k].y1 - (rot[k].x1 >>> k);
        rot_next.z1 = rot[k].z1 + RZ_W'(ATAN_Q16[k]);
      end
      if (rot[k].z2 >= 0) begin
        rot_next.x2 = rot[k].x2 - (rot[k].y2 >>> k);
        rot_next.y2 = rot[k].y2 + (rot[k].x2 >>> k);
        rot_next.z2 = rot[k].z2 - RZ_W'(ATAN_Q16[k]);
      end else begin
        rot_next.x2 = rot[k].x2 + (rot[k].y2 >>> k);
        rot_next.y2 = rot[k].y2 - (rot[k].x2 >>> k);
        rot_next.z2 = rot[k].z2 + RZ_W'(ATAN_Q16[k]);
      end
    end

    always_ff @(posedge clk) begin
      rot[k+1] <= rot_next;
    end
  end

  // -------------------------------------------------------------------------
  // ratio = 65536 * cos(a) / cos(60 - a), sign-magnitude restoring divider
  // -------------------------------------------------------------------------
  div_t             dv [RQ_W+1];
  div_t             d0_c;
  logic [ROT_W-1:0] mag1_c;

  always_comb begin
    mag1_c      = rot[CORDIC_STEPS].x1[ROT_W-1] ? ROT_W'(-rot[CORDIC_STEPS].x1)
                                                : ROT_W'(rot[CORDIC_STEPS].x1);
    d0_c        = '0;
    d0_c.sector = rot[CORDIC_STEPS].sector;
    d0_c.ival   = rot[CORDIC_STEPS].ival;
    d0_c.p_low  = rot[CORDIC_STEPS].p_low;
    d0_c.p_is   = rot[CORDIC_STEPS].p_is;
    d0_c.neg    = rot[CORDIC_STEPS].neg ^ rot[CORDIC_STEPS].x1[ROT_W-1];
    d0_c.rem    = RREM_W'(mag1_c) << 16;
    // non-positive divisor falls back to one
    d0_c.den    = (rot[CORDIC_STEPS].x2 <= 0) ? DEN_W'(65536)
                                              : rot[CORDIC_STEPS].x2[DEN_W-1:0];
    d0_c.quo    = '0;
  end

  always_ff @(posedge clk) begin
    dv[0] <= d0_c;
  end

  for (genvar k = 0; k < RQ_W; k++) begin : g_div
    localparam int QB = RQ_W - 1 - k;
    div_t dv_next;

    always_comb begin
      dv_next = dv[k];
      if (dv[k].rem >= (RREM_W'(dv[k].den) << QB)) begin
        dv_next.rem     = dv[k].rem - (RREM_W'(dv[k].den) << QB);
        dv_next.quo[QB] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      dv[k+1] <= dv_next;
    end
  end

  // -------------------------------------------------------------------------
  // big product i * s * ratio, low term rounding add
  // -------------------------------------------------------------------------
  logic signed [RQ_W:0]   ratio_c;
  logic [PROD_W:0]        lsum_c;
  logic [1:0]             sector_m;
  logic [IVAL_W-1:0]      ival_m;
  logic signed [P2_W-1:0] p2_m;
  logic [LM_W-1:0]        ml_m;

  always_comb begin
    ratio_c = dv[RQ_W].neg ? -$signed({1'b0, dv[RQ_W].quo}) : $signed({1'b0, dv[RQ_W].quo});
    lsum_c  = {1'b0, dv[RQ_W].p_low} + (PROD_W+1)'(SAT_FULL / 2);
  end

  always_ff @(posedge clk) begin
    sector_m <= dv[RQ_W].sector;
    ival_m   <= dv[RQ_W].ival;
    p2_m     <= P2_W'($signed({1'b0, dv[RQ_W].p_is})) * P2_W'(ratio_c);
    ml_m     <= lsum_c[PROD_W:10];
  end

  // -------------------------------------------------------------------------
  // rounding divides by 25600 and 25600 * 65536 (shift, then times 1/25)
  // -------------------------------------------------------------------------
  logic [P2_W-1:0]   pmag_c, pn_c;
  logic [39:0]       lprod_c;
  logic [1:0]        sector_r;
  logic [IVAL_W-1:0] ival_r;
  logic              sign_r;
  logic [MB_W-1:0]   mb_r;
  logic [15:0]       low_r;

  always_comb begin
    pmag_c  = p2_m[P2_W-1] ? P2_W'(-p2_m) : P2_W'(p2_m);
    pn_c    = pmag_c + P2_W'(HALF_BIG);
    lprod_c = 40'(ml_m) * 40'(RECIP25_L);
  end

  always_ff @(posedge clk) begin
    sector_r <= sector_m;
    ival_r   <= ival_m;
    sign_r   <= p2_m[P2_W-1];
    mb_r     <= pn_c[P2_W-1:26];
    low_r    <= lprod_c[24 +: 16];
  end

  logic [43:0]            bprod_c;
  logic signed [V_W-1:0]  bq_c;
  logic [1:0]             sector_q;
  logic [IVAL_W-1:0]      ival_q;
  logic [15:0]            low_q;
  logic signed [V_W-1:0]  big_q;

  always_comb begin
    bprod_c = 44'(mb_r) * 44'(RECIP25_B);
    bq_c    = $signed(V_W'(bprod_c[26 +: 18]));
    if (sign_r) begin
      bq_c = -bq_c;
    end
  end

  always_ff @(posedge clk) begin
    sector_q <= sector_r;
    ival_q   <= ival_r;
    low_q    <= low_r;
    big_q    <= $signed(V_W'(ival_r)) + bq_c;
  end

  // -------------------------------------------------------------------------
  // rest term, channel rounding and sector routing into the output register
  // -------------------------------------------------------------------------
  logic signed [V_W-1:0] low_c, rest_c;
  logic [7:0]            lo8_c, bg8_c, rs8_c;

  always_comb begin
    low_c  = $signed(V_W'(low_q));
    rest_c = $signed(V_W'(ival_q)) * V_W'(3) - low_c - big_q;
    lo8_c  = chan_out(low_c);
    bg8_c  = chan_out(big_q);
    rs8_c  = chan_out(rest_c);
  end

  always_ff @(posedge clk) begin
    case (sector_q)
      SEC_RG: begin
        blue_out  <= lo8_c;
        red_out   <= bg8_c;
        green_out <= rs8_c;
      end
      SEC_GB: begin
        red_out   <= lo8_c;
        green_out <= bg8_c;
        blue_out  <= rs8_c;
      end
      default: begin
        green_out <= lo8_c;
        blue_out  <= bg8_c;
        red_out   <= rs8_c;
      end
    endcase
  end

endmodule
